// ===== src/b64sd_pkg.sv =====
// Package for the Base64 stream decoder: beat types, codes and the symbol lookup.
`default_nettype none
package b64sd_pkg;

	localparam int QueueDepth = 8;
	localparam int PtrW       = $clog2(QueueDepth);
	localparam int MaxRes     = 3;

	localparam logic [7:0] PadChar   = 8'h3D; // '='
	localparam logic [7:0] PlusChar  = 8'h2B; // '+'
	localparam logic [7:0] SlashChar = 8'h2F; // '/'
	localparam logic [7:0] SpaceChar = 8'h20;

	typedef struct packed {
		logic [7:0] char_in;
		logic       final_char;
	} in_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_valid;
		logic       end_of_string;
		logic       bad_input;
	} out_t;

	// Results raised by one character, slot 0 goes out first.
	typedef struct packed {
		logic [1:0]              num;
		out_t [MaxRes-1:0]       res;
	} res_bundle_t;

	typedef struct packed {
		logic       ok;
		logic [5:0] val;
	} sextet_t;

	function automatic sextet_t sextet_of(input logic [7:0] c);
		sextet_t s;
		s.ok  = 1'b1;
		s.val = 6'd0;
		case (c) inside
			[8'h41:8'h5A]: s.val = 6'(c - 8'h41);
			[8'h61:8'h7A]: s.val = 6'(c - 8'h61 + 8'd26);
			[8'h30:8'h39]: s.val = 6'(c - 8'h30 + 8'd52);
			PlusChar:      s.val = 6'd62;
			SlashChar:     s.val = 6'd63;
			default:       s.ok  = 1'b0;
		endcase
		return s;
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return (c == SpaceChar) || ((c >= 8'd9) && (c <= 8'd13));
	endfunction

endpackage
`default_nettype wire

// ===== src/b64sd_decode.sv =====
// Character decode: group state registers and the per-character result logic.
`default_nettype none
module b64sd_decode (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   fire,
	input  wire b64sd_pkg::in_t         item,
	output b64sd_pkg::res_bundle_t      results
);

	logic [23:0] group_q;
	logic [1:0]  cnt_q;
	logic        pad_q;
	logic        fail_q;

	logic [23:0] group_d;
	logic [1:0]  cnt_d;
	logic        pad_d;
	logic        fail_d;

	always_comb begin
		b64sd_pkg::sextet_t sx;
		sx      = b64sd_pkg::sextet_of(item.char_in);
		group_d = group_q;
		cnt_d   = cnt_q;
		pad_d   = pad_q;
		fail_d  = fail_q;
		results = '0;

		if (!fail_q) begin
			if (pad_q) begin
				if (item.char_in != b64sd_pkg::PadChar) fail_d = 1'b1;
			end else if (item.char_in == b64sd_pkg::PadChar) begin
				pad_d = 1'b1;
			end else if (!b64sd_pkg::is_space(item.char_in)) begin
				if (!sx.ok) begin
					fail_d = 1'b1;
				end else begin
					group_d = {group_q[17:0], sx.val};
					if (cnt_q == 2'd3) begin
						results.res[0] = '{group_d[23:16], 1'b1, 1'b0, 1'b0};
						results.res[1] = '{group_d[15:8], 1'b1, 1'b0, 1'b0};
						results.res[2] = '{group_d[7:0], 1'b1, 1'b0, 1'b0};
						results.num    = 2'd3;
						group_d        = '0;
						cnt_d          = 2'd0;
					end else begin
						cnt_d = cnt_q + 2'd1;
					end
				end
			end
		end

		if (item.final_char) begin
			if (fail_d) begin
				results.res[0] = '{8'd0, 1'b0, 1'b1, 1'b1};
				results.num    = 2'd1;
			end else if (results.num == 2'd3) begin
				results.res[2].end_of_string = 1'b1;
			end else if (cnt_d == 2'd2) begin
				results.res[0] = '{group_d[11:4], 1'b1, 1'b1, 1'b0};
				results.num    = 2'd1;
			end else if (cnt_d == 2'd3) begin
				results.res[0] = '{group_d[17:10], 1'b1, 1'b0, 1'b0};
				results.res[1] = '{group_d[9:2], 1'b1, 1'b1, 1'b0};
				results.num    = 2'd2;
			end else begin
				// nothing left over, or a lone sextet that is dropped
				results.res[0] = '{8'd0, 1'b0, 1'b1, 1'b0};
				results.num    = 2'd1;
			end
			group_d = '0;
			cnt_d   = 2'd0;
			pad_d   = 1'b0;
			fail_d  = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_q <= '0;
			cnt_q   <= '0;
			pad_q   <= 1'b0;
			fail_q  <= 1'b0;
		end else if (fire) begin
			group_q <= group_d;
			cnt_q   <= cnt_d;
			pad_q   <= pad_d;
			fail_q  <= fail_d;
		end
	end

endmodule
`default_nettype wire

// ===== src/b64sd_queue.sv =====
// Result queue: takes up to three result beats per cycle, hands out one per cycle while res_ready is high.
`default_nettype none
module b64sd_queue (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   push,
	input  wire b64sd_pkg::res_bundle_t wr,
	output logic                        room,
	output logic                        res_valid,
	input  wire logic                   res_ready,
	output b64sd_pkg::out_t             res_data
);

	localparam int CntW = $clog2(b64sd_pkg::QueueDepth + 1);

	b64sd_pkg::out_t                     mem_q [b64sd_pkg::QueueDepth];
	logic [b64sd_pkg::PtrW-1:0]          wr_ptr_q;
	logic [b64sd_pkg::PtrW-1:0]          rd_ptr_q;
	logic [CntW-1:0]                     count_q;
	logic                                pop;
	logic [1:0]                          n_push;

	assign pop       = res_valid && res_ready;
	assign n_push    = push ? wr.num : 2'd0;
	assign res_valid = (count_q != '0);
	assign res_data  = mem_q[rd_ptr_q];
	assign room      = (count_q <= CntW'(b64sd_pkg::QueueDepth - b64sd_pkg::MaxRes));

	always_ff @(posedge clk) begin
		for (int k = 0; k < b64sd_pkg::MaxRes; k++) begin
			if (k < int'(n_push))
				mem_q[b64sd_pkg::PtrW'(int'(wr_ptr_q) + k)] <= wr.res[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + b64sd_pkg::PtrW'(n_push);
			if (pop) rd_ptr_q <= rd_ptr_q + b64sd_pkg::PtrW'(1);
			count_q <= count_q + CntW'(n_push) - CntW'(pop);
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(n_push != 2'd0) |-> room)
		else $error("queue written without room for a full burst");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntW'(b64sd_pkg::QueueDepth))
		else $error("queue count beyond depth");
	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> count_q == $past(count_q) + CntW'($past(n_push)) - CntW'($past(pop)))
		else $error("queue count out of step with pushes and pops");
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		b64sd_pkg::PtrW'(wr_ptr_q - rd_ptr_q) == b64sd_pkg::PtrW'(count_q))
		else $error("queue pointers disagree with count");
`endif

endmodule
`default_nettype wire

// ===== src/base64_stream_decoder_core.sv =====
// Top level of the Base64 stream decoder: input register, decode and result queue.
// A character beat waits in the input register until the queue has room for three
// beats, then is decoded; its result beats, if any, are written into the queue as it is decoded.
// Throughput: one character per cycle; results leave one beat per cycle while res_ready
// is high, from an eight-entry queue; input stalls only while fewer than three are free.
// Reset (arst_n low) clears the group state and input valid flag and empties the queue.
`default_nettype none
module base64_stream_decoder_core (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            src_valid,
	output logic                 src_ready,
	input  wire b64sd_pkg::in_t  src_data,
	output logic                 res_valid,
	input  wire logic            res_ready,
	output b64sd_pkg::out_t      res_data
);

	b64sd_pkg::in_t         item_s1;
	logic                   valid_s1;
	logic                   fire;
	logic                   room;
	b64sd_pkg::res_bundle_t results;

	assign fire      = valid_s1 && room;
	assign src_ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (src_ready) begin
			valid_s1 <= src_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (src_ready && src_valid) item_s1 <= src_data;
	end

	b64sd_decode u_decode (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.item    (item_s1),
		.results (results)
	);

	b64sd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (fire),
		.wr        (results),
		.room      (room),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_data  (res_data)
	);

endmodule
`default_nettype wire
